// ----- design/assert_macros.svh -----
// Assertion macros for the escape decoder design.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge; ignored while reset is held.
`define QSED_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define QSED_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ----- design/qsed_pkg.sv -----
// Shared types, character codes and decode helpers for the escape decoder.
// No dependencies.
package qsed_pkg;

    // escape stage codes
    localparam logic [2:0] ST_IDLE   = 3'd0; // plain text
    localparam logic [2:0] ST_BSLASH = 3'd1; // after backslash
    localparam logic [2:0] ST_OCT1   = 3'd2; // one octal digit seen
    localparam logic [2:0] ST_OCT2   = 3'd3; // two octal digits, or after 'x'
    localparam logic [2:0] ST_OCT3   = 3'd4; // three octal digits, or one hex digit
    localparam logic [2:0] ST_HEX2   = 3'd5; // two hex digits

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_B   = 8'h62;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_N   = 8'h6E;
    localparam logic [7:0] CH_LO_R   = 8'h72;
    localparam logic [7:0] CH_LO_T   = 8'h74;
    localparam logic [7:0] CH_LO_V   = 8'h76;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;

    localparam logic [7:0] CC_BEL = 8'h07;
    localparam logic [7:0] CC_BS  = 8'h08;
    localparam logic [7:0] CC_TAB = 8'h09;
    localparam logic [7:0] CC_LF  = 8'h0A;
    localparam logic [7:0] CC_VT  = 8'h0B;
    localparam logic [7:0] CC_FF  = 8'h0C;
    localparam logic [7:0] CC_CR  = 8'h0D;

    localparam int unsigned RES_SLOTS = 3;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       byte_valid;
        logic       run_end;
        logic       string_end;
        logic       bad_escape;
    } res_t;

    function automatic logic is_octal(input logic [7:0] c);
        return c[7:3] == 5'b00110;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LO_A && c <= CH_LO_F) ||
               (c >= CH_UP_A && c <= CH_UP_F);
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        if (c <= CH_NINE) begin
            d = c - CH_ZERO;
        end else if (c >= CH_LO_A) begin
            d = c - CH_LO_A + 8'd10;
        end else begin
            d = c - CH_UP_A + 8'd10;
        end
        return d[3:0];
    endfunction

    function automatic logic [7:0] map_escape(input logic [7:0] c);
        logic [7:0] m;
        unique case (c)
            CH_LO_A: m = CC_BEL;
            CH_LO_B: m = CC_BS;
            CH_LO_T: m = CC_TAB;
            CH_LO_R: m = CC_CR;
            CH_LO_N: m = CC_LF;
            CH_LO_V: m = CC_VT;
            CH_LO_F: m = CC_FF;
            default: m = c;
        endcase
        return m;
    endfunction

    function automatic res_t mk_res(input logic [7:0] b, input logic v, input logic bad);
        res_t r;
        r.byte_out   = b;
        r.byte_valid = v;
        r.run_end    = 1'b0;
        r.string_end = 1'b0;
        r.bad_escape = bad;
        return r;
    endfunction

endpackage

// ----- design/quoted_string_escape_decoder.sv -----
// Results are registered in the result queue and leave on the m_ ports in order.
// Throughput: one byte per cycle while each gives at most one result and m_ready is high.
// A byte giving two (flushed numeric value plus a character or a bad-escape result) leaves
// at least two in the three-slot result queue, and the input stalls while two or more wait.
// Reset (synchronous, aresetn low): escape state cleared, result queue emptied.
// Depends on qsed_pkg and assert_macros.svh.
`include "assert_macros.svh"

module quoted_string_escape_decoder
    import qsed_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_byte_in,
    input  logic       s_last_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_byte_out,
    output logic       m_byte_valid,
    output logic       m_run_end,
    output logic       m_string_end,
    output logic       m_bad_escape
);

    logic [2:0] stage_reg, stage_next;
    logic       hex_reg, hex_next;
    logic [7:0] pend_reg, pend_next;

    res_t       q_reg [RES_SLOTS];
    res_t       q_next [RES_SLOTS];
    logic [1:0] count_reg, count_next;

    res_t       res_v [2];
    logic [1:0] n_v;
    logic [1:0] base;
    logic       push, pop;

    assign s_ready = count_reg < 2'd2;
    assign m_valid = count_reg != 2'd0;
    assign push    = s_valid && s_ready;
    assign pop     = m_valid && m_ready;

    // escape decode of one byte: next state and up to two results
    always_comb begin
        stage_next = stage_reg;
        hex_next   = hex_reg;
        pend_next  = pend_reg;
        n_v        = 2'd0;
        res_v[0]   = mk_res(8'd0, 1'b0, 1'b0);
        res_v[1]   = mk_res(8'd0, 1'b0, 1'b0);

        if (stage_reg == ST_IDLE) begin
            if (s_byte_in == CH_BSLASH) begin
                stage_next = ST_BSLASH;
            end else begin
                res_v[n_v[0]] = mk_res(s_byte_in, 1'b1, 1'b0);
                n_v = n_v + 2'd1;
            end
        end else if (stage_reg == ST_BSLASH) begin
            if (is_octal(s_byte_in)) begin
                pend_next  = {5'd0, s_byte_in[2:0]};
                hex_next   = 1'b0;
                stage_next = ST_OCT1;
            end else begin
                stage_next = ST_IDLE;
                res_v[n_v[0]] = mk_res(map_escape(s_byte_in), 1'b1, 1'b0);
                n_v = n_v + 2'd1;
            end
        end else begin
            if (stage_reg == ST_OCT1 && s_byte_in == CH_X) begin
                hex_next   = 1'b1;
                stage_next = ST_OCT2;
            end else if (hex_reg && (stage_reg == ST_OCT2 || stage_reg == ST_OCT3) &&
                         is_hex(s_byte_in)) begin
                pend_next  = {pend_reg[3:0], hex_value(s_byte_in)};
                stage_next = stage_reg + 3'd1;
            end else if (stage_reg <= ST_OCT2 && is_octal(s_byte_in)) begin
                pend_next  = {pend_reg[4:0], s_byte_in[2:0]};
                stage_next = stage_reg + 3'd1;
            end else begin
                // terminator: flush the value, then treat the byte as plain text
                res_v[n_v[0]] = mk_res(pend_reg, 1'b1, 1'b0);
                n_v = n_v + 2'd1;
                hex_next = 1'b0;
                if (s_byte_in == CH_BSLASH) begin
                    stage_next = ST_BSLASH;
                end else begin
                    stage_next = ST_IDLE;
                    res_v[n_v[0]] = mk_res(s_byte_in, 1'b1, 1'b0);
                    n_v = n_v + 2'd1;
                end
            end
        end

        if (s_last_byte) begin
            if (stage_next >= ST_OCT1) begin
                res_v[n_v[0]] = mk_res(pend_next, 1'b1, 1'b0);
                n_v = n_v + 2'd1;
            end else if (stage_next == ST_BSLASH) begin
                res_v[n_v[0]] = mk_res(8'd0, 1'b0, 1'b1);
                n_v = n_v + 2'd1;
            end
            stage_next = ST_IDLE;
            hex_next   = 1'b0;
            pend_next  = 8'd0;
        end

        if (n_v == 2'd1) begin
            res_v[0].run_end    = 1'b1;
            res_v[0].string_end = s_last_byte;
        end else if (n_v == 2'd2) begin
            res_v[1].run_end    = 1'b1;
            res_v[1].string_end = s_last_byte;
        end
    end

    // result queue: shift on pop, append new results behind what remains
    always_comb begin
        base = pop ? count_reg - 2'd1 : count_reg;
        for (int i = 0; i < RES_SLOTS; i++) begin
            if (pop && i < RES_SLOTS - 1) begin
                q_next[i] = q_reg[i + 1];
            end else begin
                q_next[i] = q_reg[i];
            end
            if (push && n_v != 2'd0 && 2'(i) == base) begin
                q_next[i] = res_v[0];
            end
            if (push && n_v == 2'd2 && 2'(i) == base + 2'd1) begin
                q_next[i] = res_v[1];
            end
        end
        count_next = base + (push ? n_v : 2'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= ST_IDLE;
            hex_reg   <= 1'b0;
            pend_reg  <= 8'd0;
            count_reg <= 2'd0;
        end else begin
            if (push) begin
                stage_reg <= stage_next;
                hex_reg   <= hex_next;
                pend_reg  <= pend_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < RES_SLOTS; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

    assign m_byte_out   = q_reg[0].byte_out;
    assign m_byte_valid = q_reg[0].byte_valid;
    assign m_run_end    = q_reg[0].run_end;
    assign m_string_end = q_reg[0].string_end;
    assign m_bad_escape = q_reg[0].bad_escape;

    `QSED_ASSERT(a_hex_stage,
        hex_reg |-> (stage_reg == ST_OCT2 || stage_reg == ST_OCT3 || stage_reg == ST_HEX2),
        "hex mode outside hex stages")
    `QSED_ASSERT(a_last_clears,
        (s_valid && s_ready && s_last_byte) |=>
            (stage_reg == ST_IDLE && !hex_reg && pend_reg == 8'd0),
        "escape state not cleared after last byte")
    `QSED_ASSERT(a_end_flags, (m_valid && m_string_end) |-> m_run_end,
        "string end without run end")
    // stage is unknown until the first reset edge, so only judged once reset is released
    `QSED_ASSERT_ALWAYS(a_stage_range, !aresetn || stage_reg <= ST_HEX2,
        "escape stage out of range")

endmodule
